// ----- rtl/core/spectrum_waterfall_row_mapper_top_defines.svh -----
// Assertion shorthands for the checker of this block.
`ifndef SPECTRUM_WATERFALL_ROW_MAPPER_TOP_DEFINES_SVH
`define SPECTRUM_WATERFALL_ROW_MAPPER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SWRM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SWRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/swrm_pkg.sv -----
`default_nettype none

package swrm_pkg;

    localparam int POW_W     = 14;
    localparam int FRAME_W   = 32;
    localparam int COL_W     = 14;
    localparam int ROW_W     = 10;
    localparam int CHAN_W    = 8;
    localparam int RGB_W     = 3 * CHAN_W;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;

    localparam int DEF_LUT_ENTRIES       = 256;
    localparam int DEF_MAX_TEXTURE_WIDTH = 16384;
    localparam int DEF_TEXTURE_ROWS      = 1024;
    localparam int DEF_MAX_BINS          = 65536;

    localparam logic        [CFG_W-1:0] RST_BINS    = 17'd1024;
    localparam logic signed [POW_W-1:0] RST_FLOOR   = -14'sd1600;
    localparam logic signed [POW_W-1:0] RST_CEILING = 14'sd0;
    localparam logic signed [POW_W-1:0] PEAK_FLOOR  = -14'sd3200;
    localparam logic        [POW_W-1:0] MIN_SPAN    = 14'd16;

    localparam int QUEUE_DEPTH   = 4;
    localparam int FRAME_DIGIT_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BINS    = 2'd0,
        CFG_FLOOR   = 2'd1,
        CFG_CEILING = 2'd2
    } swrm_cfg_idx_t;

    // One pixel as handed from the front end to the back end.
    typedef struct packed {
        logic [COL_W-1:0]   col;
        logic [FRAME_W-1:0] frame;
        logic               last;
        logic [POW_W-1:0]   diff;
        logic [POW_W-1:0]   span;
    } swrm_pix_t;

    // Jet channel: 1.5 - |4i/d - c|, clamped to [0,1], times 255, truncated.
    function automatic logic [CHAN_W-1:0] jet_channel(int i, int d, int c);
        int a;
        int num;
        int r;
        int v;
        a = 4 * i - c * d;
        if (a < 0)
        begin
            a = -a;
        end
        num = 3 * d - 2 * a;
        r = 0;
        if (num >= 2 * d)
        begin
            r = 255;
        end
        else if (num > 0)
        begin
            for (v = 1; v < 255; v++)
            begin
                if (v * 2 * d <= num * 255)
                begin
                    r = r + 1;
                end
            end
        end
        return CHAN_W'(r);
    endfunction

    function automatic logic [RGB_W-1:0] jet_entry(int i, int d);
        return {jet_channel(i, d, 3), jet_channel(i, d, 2), jet_channel(i, d, 1)};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/spectrum_waterfall_row_mapper_top.sv -----
// channel  | handshake                      | fields
// ---------+--------------------------------+------------------------------------------
// bins in  | push / full, taken: push&!full | bin_power, frame_number
// pixels   | empty / pop, taken: pop&!empty | pixel_column, texture_row, red, green,
//          |                                | blue, row_done
// config   | cfg_write, no wait             | cfg_index, cfg_data
//
// The front end takes one bin per cycle while the pixel queue has room.
// The back end steps each pixel through its multiply, divide and lookup states, one pixel
// at a time; the quotient and the row modulo are worked out together in the divide state.
// A result waits in the output register without stopping the front end; full rises
// only when the pixel queue fills. Reset is immediate, with no clearing pass.
`default_nettype none

module spectrum_waterfall_row_mapper_top import swrm_pkg::*;
#(
    parameter int LUT_ENTRIES       = DEF_LUT_ENTRIES,
    parameter int MAX_TEXTURE_WIDTH = DEF_MAX_TEXTURE_WIDTH,
    parameter int TEXTURE_ROWS      = DEF_TEXTURE_ROWS,
    parameter int MAX_BINS          = DEF_MAX_BINS
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    output logic                         full,
    input  wire logic signed [POW_W-1:0] bin_power,
    input  wire logic [FRAME_W-1:0]      frame_number,
    output logic                         empty,
    input  wire logic                    pop,
    output logic [COL_W-1:0]             pixel_column,
    output logic [ROW_W-1:0]             texture_row,
    output logic [CHAN_W-1:0]            red,
    output logic [CHAN_W-1:0]            green,
    output logic [CHAN_W-1:0]            blue,
    output logic                         row_done,
    input  wire logic                    cfg_write,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data
);

    logic      take;
    logic      emit;
    swrm_pix_t pix;
    logic      q_full;
    logic      q_empty;
    logic      q_rd;
    swrm_pix_t q_data;

    assign full = q_full;
    assign take = push && !q_full;

    swrm_front #(
        .MAX_TEXTURE_WIDTH (MAX_TEXTURE_WIDTH),
        .MAX_BINS          (MAX_BINS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .take         (take),
        .bin_power    (bin_power),
        .frame_number (frame_number),
        .emit         (emit),
        .pix          (pix)
    );

    swrm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (emit),
        .wr_data (pix),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    swrm_back #(
        .LUT_ENTRIES  (LUT_ENTRIES),
        .TEXTURE_ROWS (TEXTURE_ROWS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_rd         (q_rd),
        .q_data       (q_data),
        .pop          (pop),
        .empty        (empty),
        .pixel_column (pixel_column),
        .texture_row  (texture_row),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .row_done     (row_done)
    );

endmodule

`default_nettype wire

// ----- rtl/core/swrm_queue.sv -----
`default_nettype none

module swrm_queue import swrm_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      wr_en,
    input  wire swrm_pix_t wr_data,
    output logic           full,
    input  wire logic      rd_en,
    output swrm_pix_t      rd_data,
    output logic           empty
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    swrm_pix_t         slots_reg [QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg,  count_next;
    logic              do_wr, do_rd;

    assign full    = (count_reg == CW'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (!do_wr && do_rd)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/swrm_front.sv -----
`default_nettype none

module swrm_front import swrm_pkg::*;
#(
    parameter int MAX_TEXTURE_WIDTH = DEF_MAX_TEXTURE_WIDTH,
    parameter int MAX_BINS          = DEF_MAX_BINS
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_write,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data,
    input  wire logic                    take,
    input  wire logic signed [POW_W-1:0] bin_power,
    input  wire logic [FRAME_W-1:0]      frame_number,
    output logic                         emit,
    output swrm_pix_t                    pix
);

    localparam int HW    = $clog2(MAX_BINS / 2 + 1);
    localparam int TW    = $clog2(MAX_TEXTURE_WIDTH / 2 + 1);
    localparam int ACC_W = $clog2((MAX_TEXTURE_WIDTH / 2) * (MAX_BINS / 2 + 1) + 1);

    typedef struct packed {
        logic [HW-1:0] fh;
        logic [TW-1:0] th;
    } geom_t;

    // Clamp the FFT size, force it even, derive half size and half texture width.
    function automatic geom_t geom_of(logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] f;
        logic [CFG_W-1:0] w;
        geom_t            g;
        f = v;
        if (f < CFG_W'(2))
        begin
            f = CFG_W'(2);
        end
        if (f > CFG_W'(MAX_BINS))
        begin
            f = CFG_W'(MAX_BINS);
        end
        f[0] = 1'b0;
        w = (f < CFG_W'(MAX_TEXTURE_WIDTH)) ? f : CFG_W'(MAX_TEXTURE_WIDTH);
        g.fh = HW'(f >> 1);
        g.th = TW'(w >> 1);
        return g;
    endfunction

    localparam geom_t RST_GEOM = geom_of(RST_BINS);

    logic [HW-1:0]          fh_reg,    fh_next;
    logic [TW-1:0]          th_reg,    th_next;
    logic signed [POW_W-1:0] floor_reg, floor_next;
    logic signed [POW_W-1:0] ceil_reg,  ceil_next;
    logic signed [POW_W-1:0] peak_reg,  peak_next;
    logic [HW-1:0]          local_reg, local_next;
    logic [TW-1:0]          pc_reg,    pc_next;
    logic                   upper_reg, upper_next;
    logic [ACC_W-1:0]       a_reg,     a_next;
    logic [ACC_W-1:0]       b_reg,     b_next;

    geom_t                  g_new;
    logic signed [POW_W-1:0] peak_new;
    logic signed [POW_W:0]  gap;
    logic signed [POW_W:0]  span_x;
    logic                   end_hit;
    logic                   half_end;
    logic                   pc_end;
    logic                   last;

    assign g_new    = geom_of(cfg_data);
    assign peak_new = (bin_power > peak_reg) ? bin_power : peak_reg;
    // a holds (pixel+1)*fh, b holds (local+2)*th: the range ends when a < b.
    assign end_hit  = (a_reg < b_reg);
    assign half_end = ((local_reg + HW'(1)) == fh_reg);
    assign pc_end   = ((pc_reg + TW'(1)) == th_reg);
    assign last     = upper_reg && half_end;
    assign gap      = $signed({peak_new[POW_W-1], peak_new})
                    - $signed({floor_reg[POW_W-1], floor_reg});
    assign span_x   = $signed({ceil_reg[POW_W-1], ceil_reg})
                    - $signed({floor_reg[POW_W-1], floor_reg});

    assign emit = take && end_hit;

    always_comb
    begin
        pix.col   = upper_reg ? COL_W'(pc_reg) : COL_W'(th_reg) + COL_W'(pc_reg);
        pix.frame = frame_number;
        pix.last  = last;
        pix.diff  = (!gap[POW_W] && gap != '0) ? gap[POW_W-1:0] : '0;
        if (span_x[POW_W] || $unsigned(span_x) < (POW_W+1)'(MIN_SPAN))
        begin
            pix.span = MIN_SPAN;
        end
        else
        begin
            pix.span = span_x[POW_W-1:0];
        end
    end

    always_comb
    begin
        fh_next    = fh_reg;
        th_next    = th_reg;
        floor_next = floor_reg;
        ceil_next  = ceil_reg;
        peak_next  = peak_reg;
        local_next = local_reg;
        pc_next    = pc_reg;
        upper_next = upper_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        if (cfg_write)
        begin
            unique case (swrm_cfg_idx_t'(cfg_index))
                CFG_BINS:
                begin
                    // Abandon the row in flight.
                    fh_next    = g_new.fh;
                    th_next    = g_new.th;
                    peak_next  = PEAK_FLOOR;
                    local_next = '0;
                    pc_next    = '0;
                    upper_next = 1'b0;
                    a_next     = ACC_W'(g_new.fh);
                    b_next     = ACC_W'(g_new.th) << 1;
                end
                CFG_FLOOR:
                begin
                    floor_next = $signed(cfg_data[POW_W-1:0]);
                end
                CFG_CEILING:
                begin
                    ceil_next = $signed(cfg_data[POW_W-1:0]);
                end
                default:
                begin
                end
            endcase
        end
        else if (take)
        begin
            if (!end_hit)
            begin
                peak_next  = peak_new;
                local_next = local_reg + HW'(1);
                b_next     = b_reg + ACC_W'(th_reg);
            end
            else
            begin
                peak_next = PEAK_FLOOR;
                if (last)
                begin
                    local_next = '0;
                    pc_next    = '0;
                    upper_next = 1'b0;
                    a_next     = ACC_W'(fh_reg);
                    b_next     = ACC_W'(th_reg) << 1;
                end
                else
                begin
                    if (half_end || pc_end)
                    begin
                        pc_next = '0;
                        a_next  = ACC_W'(fh_reg);
                    end
                    else
                    begin
                        pc_next = pc_reg + TW'(1);
                        a_next  = a_reg + ACC_W'(fh_reg);
                    end
                    if (half_end)
                    begin
                        // Advance into the upper half.
                        local_next = '0;
                        upper_next = 1'b1;
                        b_next     = ACC_W'(th_reg) << 1;
                    end
                    else
                    begin
                        local_next = local_reg + HW'(1);
                        b_next     = b_reg + ACC_W'(th_reg);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fh_reg    <= RST_GEOM.fh;
            th_reg    <= RST_GEOM.th;
            floor_reg <= RST_FLOOR;
            ceil_reg  <= RST_CEILING;
            peak_reg  <= PEAK_FLOOR;
            local_reg <= '0;
            pc_reg    <= '0;
            upper_reg <= 1'b0;
            a_reg     <= ACC_W'(RST_GEOM.fh);
            b_reg     <= ACC_W'(RST_GEOM.th) << 1;
        end
        else
        begin
            fh_reg    <= fh_next;
            th_reg    <= th_next;
            floor_reg <= floor_next;
            ceil_reg  <= ceil_next;
            peak_reg  <= peak_next;
            local_reg <= local_next;
            pc_reg    <= pc_next;
            upper_reg <= upper_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/swrm_back.sv -----
`default_nettype none

module swrm_back import swrm_pkg::*;
#(
    parameter int LUT_ENTRIES  = DEF_LUT_ENTRIES,
    parameter int TEXTURE_ROWS = DEF_TEXTURE_ROWS
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      q_empty,
    output logic           q_rd,
    input  wire swrm_pix_t q_data,
    input  wire logic      pop,
    output logic           empty,
    output logic [COL_W-1:0]  pixel_column,
    output logic [ROW_W-1:0]  texture_row,
    output logic [CHAN_W-1:0] red,
    output logic [CHAN_W-1:0] green,
    output logic [CHAN_W-1:0] blue,
    output logic              row_done
);

    localparam int QW        = $clog2(LUT_ENTRIES);
    localparam int D         = LUT_ENTRIES - 1;
    localparam int NW        = POW_W + QW;
    localparam int MW        = $clog2(TEXTURE_ROWS) + 2;
    localparam int MOD_STEPS = FRAME_W / FRAME_DIGIT_W;
    localparam int NSTEP     = (QW > MOD_STEPS) ? QW : MOD_STEPS;
    localparam int SW        = $clog2(NSTEP);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_LOOK = 4'b1000
    } back_state_t;

    back_state_t        state_reg, state_next;
    swrm_pix_t          work_reg,  work_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [NW-1:0]      rem_reg,   rem_next;
    logic [NW-1:0]      dv_reg,    dv_next;
    logic [QW-1:0]      q_reg,     q_next;
    logic               ovf_reg,   ovf_next;
    logic [MW-1:0]      mod_reg,   mod_next;
    logic [SW-1:0]      step_reg,  step_next;

    logic               out_valid_reg, out_valid_next;
    logic [COL_W-1:0]   col_out_reg,   col_out_next;
    logic [ROW_W-1:0]   row_out_reg,   row_out_next;
    logic [RGB_W-1:0]   rgb_out_reg,   rgb_out_next;
    logic               last_out_reg,  last_out_next;

    logic [RGB_W-1:0]   rom [LUT_ENTRIES];
    logic               quo_bit;
    logic [NW-1:0]      rem_sub;
    logic               ovf_now;
    logic               q_active;
    logic               mod_active;
    logic [MW-1:0]      mod_step;
    logic [QW-1:0]      q_clamp;
    logic               out_free;
    logic [MW+ROW_W-1:0] row_wide;

    for (genvar g = 0; g < LUT_ENTRIES; g++)
    begin : g_rom
        assign rom[g] = jet_entry(g, D);
    end

    assign quo_bit    = (rem_reg >= dv_reg);
    assign rem_sub    = rem_reg - dv_reg;
    // Quotient would not fit the index width: saturate.
    assign ovf_now    = ({1'b0, rem_reg} >= ((NW+1)'(work_reg.span) << QW));
    assign q_active   = (int'(step_reg) < QW);
    assign mod_active = (int'(step_reg) < MOD_STEPS);
    assign q_clamp    = (ovf_reg || q_reg > QW'(D)) ? QW'(D) : q_reg;
    assign out_free   = !out_valid_reg || pop;
    assign row_wide   = (MW+ROW_W)'(mod_reg);

    // Reduce the frame number modulo TEXTURE_ROWS, FRAME_DIGIT_W bits at a time, most significant first.
    always_comb
    begin
        mod_step = mod_reg;
        for (int j = 0; j < FRAME_DIGIT_W; j++)
        begin
            mod_step = {mod_step[MW-2:0], frame_reg[FRAME_W-1-j]};
            if (mod_step >= MW'(TEXTURE_ROWS))
            begin
                mod_step = mod_step - MW'(TEXTURE_ROWS);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        work_next      = work_reg;
        frame_next     = frame_reg;
        rem_next       = rem_reg;
        dv_next        = dv_reg;
        q_next         = q_reg;
        ovf_next       = ovf_reg;
        mod_next       = mod_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !pop;
        col_out_next   = col_out_reg;
        row_out_next   = row_out_reg;
        rgb_out_next   = rgb_out_reg;
        last_out_next  = last_out_reg;
        q_rd           = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_rd       = 1'b1;
                    work_next  = q_data;
                    frame_next = q_data.frame;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                rem_next   = NW'(work_reg.diff) * NW'(D);
                dv_next    = NW'(work_reg.span) << (QW - 1);
                q_next     = '0;
                ovf_next   = 1'b0;
                mod_next   = '0;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (step_reg == '0)
                begin
                    ovf_next = ovf_now;
                end
                if (q_active)
                begin
                    q_next  = QW'({q_reg, quo_bit});
                    dv_next = dv_reg >> 1;
                    if (quo_bit)
                    begin
                        rem_next = rem_sub;
                    end
                end
                if (mod_active)
                begin
                    mod_next   = mod_step;
                    frame_next = frame_reg << FRAME_DIGIT_W;
                end
                step_next = step_reg + SW'(1);
                if (int'(step_reg) == NSTEP - 1)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                // Hold until the output register is free.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    col_out_next   = work_reg.col;
                    row_out_next   = row_wide[ROW_W-1:0];
                    rgb_out_next   = rom[q_clamp];
                    last_out_next  = work_reg.last;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            ovf_reg       <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg     <= work_next;
        frame_reg    <= frame_next;
        rem_reg      <= rem_next;
        dv_reg       <= dv_next;
        q_reg        <= q_next;
        mod_reg      <= mod_next;
        col_out_reg  <= col_out_next;
        row_out_reg  <= row_out_next;
        rgb_out_reg  <= rgb_out_next;
        last_out_reg <= last_out_next;
    end

    assign empty        = !out_valid_reg;
    assign pixel_column = col_out_reg;
    assign texture_row  = row_out_reg;
    assign red          = rgb_out_reg[RGB_W-1 -: CHAN_W];
    assign green        = rgb_out_reg[2*CHAN_W-1 -: CHAN_W];
    assign blue         = rgb_out_reg[CHAN_W-1:0];
    assign row_done     = last_out_reg;

endmodule

`default_nettype wire

// ----- rtl/core/swrm_checker.sv -----
`default_nettype none
`include "spectrum_waterfall_row_mapper_top_defines.svh"

module swrm_checker import swrm_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    push,
    input wire logic                    full,
    input wire logic                    empty,
    input wire logic                    pop,
    input wire logic [COL_W-1:0]        pixel_column,
    input wire logic [ROW_W-1:0]        texture_row,
    input wire logic [CHAN_W-1:0]       red,
    input wire logic [CHAN_W-1:0]       green,
    input wire logic [CHAN_W-1:0]       blue,
    input wire logic                    row_done
);

    localparam int PEND_W = 40;

    logic [PEND_W-1:0] pend_reg, pend_next;
    logic              in_take;
    logic              out_take;

    assign in_take  = push && !full;
    assign out_take = pop && !empty;

    // Count accepted bins not yet answered by a popped pixel.
    always_comb
    begin
        pend_next = pend_reg;
        if (in_take && !out_take)
        begin
            pend_next = pend_reg + PEND_W'(1);
        end
        else if (!in_take && out_take)
        begin
            pend_next = pend_reg - PEND_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    `SWRM_ASSERT_NEXT(a_result_held, clk, rst_n, !empty && !pop,
        !empty && $stable(pixel_column) && $stable(texture_row)
            && $stable(red) && $stable(green) && $stable(blue) && $stable(row_done),
        "stalled pixel transaction changed")
    `SWRM_ASSERT_NOW(a_no_phantom, clk, rst_n, !empty, pend_reg != '0,
        "pixel shown with no accepted bin behind it")
    `SWRM_ASSERT_NOW(a_full_backed, clk, rst_n, full, pend_reg >= PEND_W'(QUEUE_DEPTH),
        "full raised with too few bins in flight")
    `SWRM_ASSERT_NOW(a_jet_ends, clk, rst_n, !empty, !(red == 8'hFF && blue == 8'hFF),
        "colormap entry saturates red and blue together")

endmodule

bind spectrum_waterfall_row_mapper_top swrm_checker u_swrm_checker (.*);

`default_nettype wire

// ----- tb/tb_spectrum_waterfall_row_mapper_top.sv -----
module tb_spectrum_waterfall_row_mapper_top import swrm_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LUT_MAX     = DEF_LUT_ENTRIES - 1;
    localparam int NOISE_FLOOR = -3200;
    localparam int MIN_DB_SPAN = 16;
    localparam int SETTLE      = 24;
    localparam int HOLD_CYCLES = 300;
    localparam int RUN_LIMIT   = 400000;
    localparam int PHASES      = 16;
    localparam int PHASE_BINS  = 72;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum int {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_e;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
        logic              done;
    } pixel_t;

    typedef struct packed {
        logic                    is_cfg;
        logic [CFG_IDX_W-1:0]    index;
        logic [CFG_W-1:0]        data;
        logic signed [POW_W-1:0] power;
        logic [FRAME_W-1:0]      frame;
        logic                    typed;
        pixel_t                  want;
    } plan_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    push;
    logic                    full;
    logic signed [POW_W-1:0] bin_power;
    logic [FRAME_W-1:0]      frame_number;
    logic                    empty;
    logic                    pop;
    logic [COL_W-1:0]        pixel_column;
    logic [ROW_W-1:0]        texture_row;
    logic [CHAN_W-1:0]       red;
    logic [CHAN_W-1:0]       green;
    logic [CHAN_W-1:0]       blue;
    logic                    row_done;
    logic                    cfg_write;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]        cfg_data;

    spectrum_waterfall_row_mapper_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .bin_power    (bin_power),
        .frame_number (frame_number),
        .empty        (empty),
        .pop          (pop),
        .pixel_column (pixel_column),
        .texture_row  (texture_row),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .row_done     (row_done),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Mirror of the block: registers and row state.
    logic [CFG_W-1:0] fft_bins_reg;
    int               floor_lvl;
    int               ceil_lvl;
    int               peak_lvl;
    int unsigned      bin_pos;
    int unsigned      pix_pos;

    pixel_t    expected_pixels[$];
    plan_row_t directed_plan[$];
    int        mismatches;
    pace_e     pace;
    bit        hold_req;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        repeat (RUN_LIMIT) @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    function automatic void add_row(plan_row_t p);
        directed_plan.insert(directed_plan.size(), p);
    endfunction

    function automatic void expect_pixel(pixel_t px);
        expected_pixels.insert(expected_pixels.size(), px);
    endfunction

    function automatic int unsigned row_length();
        int unsigned f;
        f = fft_bins_reg;
        if (f < 2)
        begin
            f = 2;
        end
        if (f > DEF_MAX_BINS)
        begin
            f = DEF_MAX_BINS;
        end
        return f & ~32'd1;
    endfunction

    function automatic logic [CHAN_W-1:0] jet_level(int i, int c);
        int a;
        int num;
        a = 4 * i - c * LUT_MAX;
        if (a < 0)
        begin
            a = -a;
        end
        num = 3 * LUT_MAX - 2 * a;
        if (num <= 0)
        begin
            return '0;
        end
        if (num >= 2 * LUT_MAX)
        begin
            return 8'd255;
        end
        return CHAN_W'((num * 255) / (2 * LUT_MAX));
    endfunction

    function automatic void restart_row();
        peak_lvl = NOISE_FLOOR;
        bin_pos  = 0;
        pix_pos  = 0;
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
        case (index)
            CFG_BINS:
            begin
                fft_bins_reg = data;
                restart_row();
            end
            CFG_FLOOR:   floor_lvl = int'($signed(data[POW_W-1:0]));
            CFG_CEILING: ceil_lvl = int'($signed(data[POW_W-1:0]));
            default:     ;
        endcase
    endfunction

    // Advance the row by one bin; report a pixel when its range closes.
    function automatic bit map_bin(logic signed [POW_W-1:0] pw, logic [FRAME_W-1:0] fr,
                                   output pixel_t px);
        int unsigned f;
        int unsigned half;
        int unsigned half_cols;
        int unsigned local_bin;
        int unsigned range_end;
        int          span;
        int          excess;
        int          index;
        bit          upper;
        bit          last;
        px        = '0;
        f         = row_length();
        half      = f / 2;
        half_cols = (f < DEF_MAX_TEXTURE_WIDTH ? f : DEF_MAX_TEXTURE_WIDTH) / 2;
        if (half_cols == 0)
        begin
            half_cols = 1;
        end
        if (bin_pos >= f)
        begin
            restart_row();
        end
        upper     = bin_pos >= half;
        local_bin = upper ? bin_pos - half : bin_pos;
        if (int'(pw) > peak_lvl)
        begin
            peak_lvl = int'(pw);
        end
        range_end = ((pix_pos + 1) * half) / half_cols;
        if (local_bin + 1 < range_end)
        begin
            bin_pos++;
            return 1'b0;
        end
        span = ceil_lvl - floor_lvl;
        if (span < MIN_DB_SPAN)
        begin
            span = MIN_DB_SPAN;
        end
        excess = peak_lvl - floor_lvl;
        if (excess <= 0)
        begin
            index = 0;
        end
        else
        begin
            index = (excess * LUT_MAX) / span;
            if (index > LUT_MAX)
            begin
                index = LUT_MAX;
            end
        end
        last    = bin_pos + 1 >= f;
        px.col  = COL_W'(upper ? pix_pos : half_cols + pix_pos);
        px.row  = ROW_W'(fr % DEF_TEXTURE_ROWS);
        px.r    = jet_level(index, 3);
        px.g    = jet_level(index, 2);
        px.b    = jet_level(index, 1);
        px.done = last;
        peak_lvl = NOISE_FLOOR;
        if (last)
        begin
            restart_row();
        end
        else
        begin
            bin_pos++;
            if (local_bin + 1 >= half || pix_pos + 1 >= half_cols)
            begin
                pix_pos = 0;
            end
            else
            begin
                pix_pos++;
            end
        end
        return 1'b1;
    endfunction

    function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
        plan_row_t p;
        p        = '0;
        p.is_cfg = 1'b1;
        p.index  = index;
        p.data   = data;
        return p;
    endfunction

    function automatic plan_row_t bin_row(logic signed [POW_W-1:0] pw, logic [FRAME_W-1:0] fr);
        plan_row_t p;
        p       = '0;
        p.power = pw;
        p.frame = fr;
        return p;
    endfunction

    function automatic plan_row_t typed_row(logic signed [POW_W-1:0] pw, logic [FRAME_W-1:0] fr,
                                            int col, int row, int r, int g, int b, bit done);
        plan_row_t p;
        p       = bin_row(pw, fr);
        p.typed = 1'b1;
        p.want  = '{col: COL_W'(col), row: ROW_W'(row), r: CHAN_W'(r), g: CHAN_W'(g),
                    b: CHAN_W'(b), done: done};
        return p;
    endfunction

    function automatic logic signed [POW_W-1:0] pick_power();
        int lo;
        int hi;
        int t;
        if ($urandom_range(0, 4) == 0)
        begin
            return POW_W'($urandom);
        end
        lo = floor_lvl - 100;
        hi = ceil_lvl + 100;
        if (lo > hi)
        begin
            t  = lo;
            lo = hi;
            hi = t;
        end
        if (lo < -8192)
        begin
            lo = -8192;
        end
        if (hi > 8191)
        begin
            hi = 8191;
        end
        return POW_W'(int'($urandom_range(hi - lo)) + lo);
    endfunction

    function automatic int send_gap_pct();
        case (pace)
            PACE_SEND_GAPS: return 49;
            PACE_BOTH:      return 24;
            default:        return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct();
        case (pace)
            PACE_RECV_STALLS: return 49;
            PACE_BOTH:        return 24;
            default:          return 0;
        endcase
    endfunction

    // Each task starts and returns just after a rising edge.
    task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        @(posedge clk);
        apply_register(index, data);
        @(negedge clk);
        cfg_write = 1'b0;
        @(posedge clk);
    endtask

    task automatic send_bin(logic signed [POW_W-1:0] pw, logic [FRAME_W-1:0] fr,
                            bit typed, pixel_t want);
        pixel_t px;
        bit     made;
        @(negedge clk);
        while (int'($urandom_range(0, 99)) < send_gap_pct())
        begin
            push = 1'b0;
            @(negedge clk);
        end
        push         = 1'b1;
        bin_power    = pw;
        frame_number = fr;
        do
        begin
            @(posedge clk);
        end
        while (full);
        made = map_bin(pw, fr, px);
        if (typed)
        begin
            expect_pixel(want);
        end
        else if (made)
        begin
            expect_pixel(px);
        end
    endtask

    task automatic release_push();
        @(negedge clk);
        push = 1'b0;
        @(posedge clk);
    endtask

    // Hold until every pixel has come out, then let the front end go quiet.
    task automatic wait_drained();
        while (expected_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic check_pixel();
        pixel_t want;
        if (expected_pixels.size() == 0)
        begin
            $error("unexpected pixel: column %0d row %0d", pixel_column, texture_row);
            mismatches++;
            return;
        end
        want = expected_pixels.pop_front();
        if (pixel_column !== want.col)
        begin
            $error("pixel_column: expected %0d, got %0d", want.col, pixel_column);
            mismatches++;
        end
        if (texture_row !== want.row)
        begin
            $error("texture_row: expected %0d, got %0d", want.row, texture_row);
            mismatches++;
        end
        if (red !== want.r)
        begin
            $error("red: expected %0d, got %0d", want.r, red);
            mismatches++;
        end
        if (green !== want.g)
        begin
            $error("green: expected %0d, got %0d", want.g, green);
            mismatches++;
        end
        if (blue !== want.b)
        begin
            $error("blue: expected %0d, got %0d", want.b, blue);
            mismatches++;
        end
        if (row_done !== want.done)
        begin
            $error("row_done: expected %0d, got %0d", want.done, row_done);
            mismatches++;
        end
    endtask

    // Pixel receiver.
    initial
    begin
        int hold_left;
        hold_left = 0;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop = 1'b0;
            end
            else
            begin
                pop = int'($urandom_range(0, 99)) >= recv_stall_pct();
            end
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                check_pixel();
            end
        end
    end

    initial
    begin
        logic [CFG_W-1:0]   data;
        logic [FRAME_W-1:0] frame;
        int unsigned        row_pos;
        int                 fl;
        int                 ce;
        mismatches   = 0;
        hold_req     = 1'b0;
        pace         = PACE_FULL;
        rst_n        = 1'b0;
        push         = 1'b0;
        bin_power    = '0;
        frame_number = '0;
        cfg_write    = 1'b0;
        cfg_index    = CFG_BINS;
        cfg_data     = '0;
        fft_bins_reg = RST_BINS;
        floor_lvl    = -1600;
        ceil_lvl     = 0;
        restart_row();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Two-bin rows: every bin is a pixel, lower half lands in column 1.
        add_row(cfg_row(CFG_BINS, 17'd2));
        add_row(typed_row(-14'sd8192, 32'h0, 1, 0, 0, 0, 127, 1'b0));
        add_row(typed_row(14'sd8191, 32'hFFFFFFFF, 0, 1023, 127, 0, 0, 1'b1));
        add_row(typed_row(-14'sd1600, 32'd1024, 1, 0, 0, 0, 127, 1'b0));
        add_row(typed_row(14'sd0, 32'd1023, 0, 1023, 127, 0, 0, 1'b1));
        add_row(bin_row(-14'sd800, 32'h12345678));
        add_row(bin_row(-14'sd1, 32'h12345678));
        // Ceiling equal to floor: span falls back to the minimum of 16 dB.
        add_row(cfg_row(CFG_CEILING, 17'h1F9C0));
        add_row(bin_row(-14'sd1592, 32'd5));
        add_row(typed_row(-14'sd1601, 32'd5, 0, 5, 0, 0, 127, 1'b1));
        // Widest span, with junk in the bits above the register.
        add_row(cfg_row(CFG_FLOOR, 17'h1E000));
        add_row(cfg_row(CFG_CEILING, 17'h01FFF));
        add_row(bin_row(-14'sd8192, 32'd7));
        add_row(typed_row(14'sd8191, 32'd7, 0, 7, 127, 0, 0, 1'b1));
        // Inverted floor and ceiling.
        add_row(cfg_row(CFG_FLOOR, 17'h01FFF));
        add_row(cfg_row(CFG_CEILING, 17'h02000));
        add_row(typed_row(14'sd8191, 32'd9, 1, 9, 0, 0, 127, 1'b0));
        add_row(cfg_row(CFG_SPARE, 17'h1FFFF));
        add_row(typed_row(-14'sd8192, 32'd9, 0, 9, 0, 0, 127, 1'b1));
        add_row(cfg_row(CFG_FLOOR, 17'h1F9C0));
        add_row(cfg_row(CFG_CEILING, 17'h00000));
        // Largest FFT, then abandon the row halfway through a range.
        add_row(cfg_row(CFG_BINS, 17'h10000));
        add_row(bin_row(14'sd100, 32'd1));
        add_row(bin_row(14'sd200, 32'd1));
        add_row(cfg_row(CFG_BINS, 17'd3));
        add_row(typed_row(-14'sd8192, 32'd1, 1, 1, 0, 0, 127, 1'b0));
        add_row(typed_row(14'sd8191, 32'd1, 0, 1, 127, 0, 0, 1'b1));
        add_row(cfg_row(CFG_BINS, 17'd1));
        add_row(typed_row(14'sd0, 32'd3, 1, 3, 127, 0, 0, 1'b0));
        add_row(cfg_row(CFG_BINS, 17'h1FFFF));
        for (int k = 0; k < 4; k++)
        begin
            add_row(bin_row(14'sd1000 - 14'(k * 700), 32'd2));
        end

        foreach (directed_plan[k])
        begin
            if (directed_plan[k].is_cfg)
            begin
                release_push();
                wait_drained();
                write_register(directed_plan[k].index, directed_plan[k].data);
            end
            else
            begin
                send_bin(directed_plan[k].power, directed_plan[k].frame,
                         directed_plan[k].typed, directed_plan[k].want);
            end
        end
        release_push();
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            pace = pace_e'(ph % 4);
            case (ph)
                3:       data = CFG_W'(32'h10000 + $urandom_range(0, 32'hFFFF));
                7:       data = 17'd16384;
                10:      data = CFG_W'($urandom_range(16385, 20000));
                12:      data = CFG_W'($urandom_range(0, 1));
                default: data = CFG_W'($urandom_range(2, 40));
            endcase
            write_register(CFG_BINS, data);
            if (ph % 3 == 0)
            begin
                write_register(CFG_FLOOR, CFG_W'($urandom));
                write_register(CFG_CEILING, CFG_W'($urandom));
            end
            else
            begin
                fl = -int'($urandom_range(500, 3000));
                ce = fl + int'($urandom_range(0, 2500));
                write_register(CFG_FLOOR, CFG_W'(fl));
                write_register(CFG_CEILING, CFG_W'(ce));
            end
            if (ph % 5 == 2)
            begin
                write_register(CFG_SPARE, CFG_W'($urandom));
            end
            if (ph == 4)
            begin
                hold_req = 1'b1;
            end
            frame   = $urandom;
            row_pos = 0;
            for (int n = 0; n < PHASE_BINS; n++)
            begin
                // Stop offering bins until the pipeline is empty.
                if (ph == 9 && n == PHASE_BINS / 2)
                begin
                    release_push();
                    while (expected_pixels.size() != 0)
                    begin
                        @(posedge clk);
                    end
                end
                if ($urandom_range(0, 19) == 0)
                begin
                    send_bin(pick_power(), $urandom, 1'b0, '0);
                end
                else
                begin
                    send_bin(pick_power(), frame, 1'b0, '0);
                end
                row_pos++;
                if (row_pos >= row_length())
                begin
                    row_pos = 0;
                    frame++;
                end
            end
            release_push();
            wait_drained();
        end

        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/swrm_pkg.sv
rtl/core/swrm_queue.sv
rtl/core/swrm_front.sv
rtl/core/swrm_back.sv
rtl/core/spectrum_waterfall_row_mapper_top.sv
rtl/core/swrm_checker.sv
tb/tb_spectrum_waterfall_row_mapper_top.sv
